### sv/caes_pkg.sv
// Package for the CRC-checked AES-256 CBC frame decrypt core.
// Holds S-box tables, GF helpers, phase/state codes and register indexes.
// No dependencies.
package caes_pkg;

    localparam logic [7:0] REPLY_OK  = 8'hA4;
    localparam logic [7:0] REPLY_BAD = 8'hA1;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_IV_HI  = 3'd4;
    localparam logic [2:0] REG_IV_LO  = 3'd5;
    localparam logic [2:0] REG_SIG    = 3'd6;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DATA = 7'b0000010,
        ST_CRCH = 7'b0000100,
        ST_CRCL = 7'b0001000,
        ST_LOAD = 7'b0010000,
        ST_RND  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    typedef logic [7:0] sbox_t [256];

    localparam sbox_t FWD_BOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam sbox_t INV_BOX = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Inverse MixColumns on one 32-bit column, byte 0 in bits 31..24
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = c[31-8*i -: 8];
            a2[i] = xtime(a[i]);
            a4[i] = xtime(a2[i]);
            a8[i] = xtime(a4[i]);
            m9[i] = a8[i] ^ a[i];
            mb[i] = a8[i] ^ a2[i] ^ a[i];
            md[i] = a8[i] ^ a4[i] ^ a[i];
            me[i] = a8[i] ^ a4[i] ^ a2[i];
        end
        inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                       m9[0] ^ me[1] ^ mb[2] ^ md[3],
                       md[0] ^ m9[1] ^ me[2] ^ mb[3],
                       mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    // One CRC-16/XMODEM byte update
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        crc_byte = c;
    endfunction

endpackage

### sv/caes_if.sv
// Valid/ready stream interfaces for the frame decrypt core.
// Depends on nothing.
interface caes_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface caes_reply_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_byte;
    logic        last_of_pair;
    logic        crc_good;
    logic        signature_match;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    modport source (output valid, output reply_byte, output last_of_pair, output crc_good,
                    output signature_match, output plain_high, output plain_low, input ready);
    modport sink   (input valid, input reply_byte, input last_of_pair, input crc_good,
                    input signature_match, input plain_high, input plain_low, output ready);
endinterface

### sv/crc_checked_aes256_cbc_frame_decrypt_core.sv
// Top level: serial frame receiver, CRC-16 check and AES-256 CBC block decrypt.
// Depends on caes_pkg and the interfaces in caes_if.sv.
//
// Channel  | Dir | Payload
// rx       | in  | rx_byte
// reply    | out | reply_byte, last_of_pair, crc_good, signature_match, plain_high/low
//
// While the frame is collected a byte is taken whenever rx is valid; the ciphertext
// goes into a 16-entry byte memory with a registered read port. On a CRC match the
// block reads the buffer back, derives the round keys on the fly and runs 14 rounds,
// one per cycle, before the reply pair; on a mismatch it goes straight to the reply pair.
// No byte is taken until both replies have been delivered. Reset clears control and config registers.
module crc_checked_aes256_cbc_frame_decrypt_core #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    caes_rx_if.sink     rx,
    caes_reply_if.source reply
);
    localparam int CW = $clog2(BLOCK_BYTES);

    // Configuration registers
    logic [255:0] key_reg;
    logic [31:0]  sig_reg;
    logic [127:0] iv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            sig_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                caes_pkg::REG_KEY0: key_reg[255:192] <= cfg_data;
                caes_pkg::REG_KEY1: key_reg[191:128] <= cfg_data;
                caes_pkg::REG_KEY2: key_reg[127:64]  <= cfg_data;
                caes_pkg::REG_KEY3: key_reg[63:0]    <= cfg_data;
                caes_pkg::REG_SIG:  sig_reg          <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Cipher byte buffer memory
    logic [7:0]    buf_mem [BLOCK_BYTES];
    logic          buf_we;
    logic [CW-1:0] buf_waddr;
    logic [CW-1:0] buf_raddr;
    logic [7:0]    buf_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_waddr] <= rx.rx_byte;
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    caes_pkg::state_t state_reg, state_next;
    logic [CW:0]   cnt_reg, cnt_next;
    logic [15:0]   crc_reg;
    logic [7:0]    crch_reg;
    logic          good_reg;
    logic          last_reg;
    logic [127:0]  ct_reg;
    logic [127:0]  st_reg;
    logic [255:0]  rk_reg;
    logic [7:0]    rcon_reg;
    logic [3:0]    rnd_reg;

    wire rx_fire    = rx.valid && rx.ready;
    wire reply_fire = reply.valid && reply.ready;

    assign rx.ready = (state_reg == caes_pkg::ST_IDLE) || (state_reg == caes_pkg::ST_DATA)
                   || (state_reg == caes_pkg::ST_CRCH) || (state_reg == caes_pkg::ST_CRCL);
    assign buf_we    = rx_fire && (state_reg == caes_pkg::ST_DATA);
    assign buf_waddr = cnt_reg[CW-1:0];
    assign buf_raddr = cnt_reg[CW-1:0];

    wire [15:0] got_crc = {crch_reg, rx.rx_byte};

    // Forward key schedule step: derive words i..i+7 from the previous eight
    function automatic logic [255:0] key_step(input logic [255:0] k, input logic [7:0] rc);
        logic [31:0] w [8];
        logic [31:0] t;
        logic [31:0] n [8];
        for (int i = 0; i < 8; i++)
            w[i] = k[255-32*i -: 32];
        t = {caes_pkg::FWD_BOX[w[7][23:16]], caes_pkg::FWD_BOX[w[7][15:8]],
             caes_pkg::FWD_BOX[w[7][7:0]], caes_pkg::FWD_BOX[w[7][31:24]]} ^ {rc, 24'h0};
        n[0] = w[0] ^ t;
        n[1] = w[1] ^ n[0];
        n[2] = w[2] ^ n[1];
        n[3] = w[3] ^ n[2];
        t = {caes_pkg::FWD_BOX[n[3][31:24]], caes_pkg::FWD_BOX[n[3][23:16]],
             caes_pkg::FWD_BOX[n[3][15:8]], caes_pkg::FWD_BOX[n[3][7:0]]};
        n[4] = w[4] ^ t;
        n[5] = w[5] ^ n[4];
        n[6] = w[6] ^ n[5];
        n[7] = w[7] ^ n[6];
        key_step = {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
    endfunction

    // Inverse key schedule step: recover the previous eight words
    function automatic logic [255:0] key_unstep(input logic [255:0] k, input logic [7:0] rc);
        logic [31:0] n [8];
        logic [31:0] w [8];
        logic [31:0] t;
        for (int i = 0; i < 8; i++)
            n[i] = k[255-32*i -: 32];
        w[7] = n[7] ^ n[6];
        w[6] = n[6] ^ n[5];
        w[5] = n[5] ^ n[4];
        t = {caes_pkg::FWD_BOX[n[3][31:24]], caes_pkg::FWD_BOX[n[3][23:16]],
             caes_pkg::FWD_BOX[n[3][15:8]], caes_pkg::FWD_BOX[n[3][7:0]]};
        w[4] = n[4] ^ t;
        w[3] = n[3] ^ n[2];
        w[2] = n[2] ^ n[1];
        w[1] = n[1] ^ n[0];
        t = {caes_pkg::FWD_BOX[w[7][23:16]], caes_pkg::FWD_BOX[w[7][15:8]],
             caes_pkg::FWD_BOX[w[7][7:0]], caes_pkg::FWD_BOX[w[7][31:24]]} ^ {rc, 24'h0};
        w[0] = n[0] ^ t;
        key_unstep = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
    endfunction

    // Inverse ShiftRows and SubBytes over the state
    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
                r[127-8*(4*c+q) -: 8] = caes_pkg::INV_BOX[s[127-8*(4*((c-q+4)%4)+q) -: 8]];
        inv_shift_sub = r;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        inv_mix = {caes_pkg::inv_mix_col(s[127:96]), caes_pkg::inv_mix_col(s[95:64]),
                   caes_pkg::inv_mix_col(s[63:32]), caes_pkg::inv_mix_col(s[31:0])};
    endfunction

    function automatic logic [7:0] rcon_back(input logic [7:0] r);
        rcon_back = r[0] ? ({1'b1, r[7:1]} ^ 8'h0d) : {1'b0, r[7:1]};
    endfunction

    // Round datapath: even rounds use the upper half of the key pair, odd the lower
    logic [127:0] sub_st;
    logic [127:0] rk_use;
    logic [127:0] after_key;
    assign sub_st   = inv_shift_sub(st_reg);
    assign rk_use   = rnd_reg[0] ? rk_reg[127:0] : rk_reg[255:128];
    assign after_key = sub_st ^ rk_use;

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            caes_pkg::ST_IDLE:
                if (rx_fire && rx.rx_byte == 8'h00)
                begin
                    state_next = caes_pkg::ST_DATA;
                    cnt_next   = '0;
                end
            caes_pkg::ST_DATA:
                if (rx_fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == (CW+1)'(BLOCK_BYTES - 1))
                        state_next = caes_pkg::ST_CRCH;
                end
            caes_pkg::ST_CRCH:
                if (rx_fire)
                    state_next = caes_pkg::ST_CRCL;
            caes_pkg::ST_CRCL:
                if (rx_fire)
                begin
                    cnt_next   = '0;
                    state_next = (got_crc == crc_reg) ? caes_pkg::ST_LOAD : caes_pkg::ST_OUT;
                end
            caes_pkg::ST_LOAD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (CW+1)'(BLOCK_BYTES))
                    state_next = caes_pkg::ST_RND;
            end
            caes_pkg::ST_RND:
                if (rnd_reg == 4'd0)
                    state_next = caes_pkg::ST_OUT;
            caes_pkg::ST_OUT:
                if (reply_fire && last_reg)
                    state_next = caes_pkg::ST_IDLE;
            default:
                state_next = caes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= caes_pkg::ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            crc_reg   <= caes_pkg::CRC_INIT;
            crch_reg  <= '0;
            good_reg  <= 1'b0;
            iv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == caes_pkg::ST_IDLE && rx_fire && rx.rx_byte == 8'h00)
                crc_reg <= caes_pkg::CRC_INIT;
            else if (buf_we)
                crc_reg <= caes_pkg::crc_byte(crc_reg, rx.rx_byte);
            if (state_reg == caes_pkg::ST_CRCH && rx_fire)
                crch_reg <= rx.rx_byte;
            if (state_reg == caes_pkg::ST_CRCL && rx_fire)
            begin
                good_reg <= (got_crc == crc_reg);
                last_reg <= 1'b0;
            end
            if (reply_fire)
                last_reg <= 1'b1;
            // Chain update on a good frame, starting IV writes take priority
            if (state_reg == caes_pkg::ST_RND && rnd_reg == 4'd0)
                iv_reg <= ct_reg;
            if (cfg_we && cfg_index == caes_pkg::REG_IV_HI)
                iv_reg[127:64] <= cfg_data;
            if (cfg_we && cfg_index == caes_pkg::REG_IV_LO)
                iv_reg[63:0] <= cfg_data;
        end
    end

    // Datapath: load ciphertext, walk key schedule back, run rounds
    always_ff @(posedge clk)
    begin
        if (state_reg == caes_pkg::ST_CRCL && rx_fire)
        begin
            rk_reg   <= key_reg;
            rcon_reg <= 8'h01;
        end
        if (state_reg == caes_pkg::ST_LOAD)
        begin
            if (cnt_reg != '0)
                ct_reg <= {ct_reg[119:0], buf_rdata_reg};
            // Walk forward to the key pair that starts with round key 14 over seven steps
            if (cnt_reg < (CW+1)'(7))
            begin
                rk_reg   <= key_step(rk_reg, rcon_reg);
                rcon_reg <= caes_pkg::xtime(rcon_reg);
            end
            // Add round key 14, then step back to the pair for rounds 12 and 13
            if (cnt_reg == (CW+1)'(BLOCK_BYTES))
            begin
                st_reg   <= {ct_reg[119:0], buf_rdata_reg} ^ rk_reg[255:128];
                rnd_reg  <= 4'd13;
                rk_reg   <= key_unstep(rk_reg, rcon_back(rcon_reg));
                rcon_reg <= rcon_back(rcon_reg);
            end
        end
        if (state_reg == caes_pkg::ST_RND)
        begin
            if (rnd_reg == 4'd0)
                st_reg <= after_key ^ iv_reg;
            else
                st_reg <= inv_mix(after_key);
            rnd_reg <= rnd_reg - 4'd1;
            // Step back one key pair after each even round other than round 0 is consumed
            if (!rnd_reg[0] && rnd_reg != 4'd0)
            begin
                rk_reg   <= key_unstep(rk_reg, rcon_back(rcon_reg));
                rcon_reg <= rcon_back(rcon_reg);
            end
        end
    end

    // Result channel
    assign reply.valid           = (state_reg == caes_pkg::ST_OUT);
    assign reply.reply_byte      = good_reg ? caes_pkg::REPLY_OK : caes_pkg::REPLY_BAD;
    assign reply.last_of_pair    = last_reg;
    assign reply.crc_good        = good_reg;
    assign reply.signature_match = good_reg && (st_reg[127:96] == sig_reg);
    assign reply.plain_high      = good_reg ? st_reg[127:64] : 64'h0;
    assign reply.plain_low       = good_reg ? st_reg[63:0] : 64'h0;

endmodule

### sv/caes_checker.sv
// Port-level checker for the frame decrypt core, with its bind.
// Depends on caes_pkg reply codes.
module caes_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       reply_valid,
    input logic       reply_ready,
    input logic [7:0] reply_byte,
    input logic       last_of_pair,
    input logic       crc_good,
    input logic [63:0] plain_high
);
    // No byte is taken while a reply waits
    a_no_rx_during_reply: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> !rx_ready) else $error("byte accepted during reply");

    // Reply code follows the CRC flag
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> ((crc_good && reply_byte == caes_pkg::REPLY_OK)
                      || (!crc_good && reply_byte == caes_pkg::REPLY_BAD)))
        else $error("reply code mismatch");

    // First of pair is followed by the second
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply_ready && !last_of_pair |=> reply_valid && last_of_pair)
        else $error("reply pair broken");

    // Failed frames carry no plaintext in plain_high
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !crc_good |-> plain_high == 64'h0) else $error("plaintext leaked");

    // Stalled reply holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_ready |=> reply_valid && $stable(last_of_pair))
        else $error("reply dropped");
endmodule

bind crc_checked_aes256_cbc_frame_decrypt_core caes_checker u_caes_checker (
    .clk(clk), .rst_n(rst_n), .rx_ready(rx.ready),
    .reply_valid(reply.valid), .reply_ready(reply.ready), .reply_byte(reply.reply_byte),
    .last_of_pair(reply.last_of_pair), .crc_good(reply.crc_good),
    .plain_high(reply.plain_high));
